// ===== hw/rtl/size_budget_lru_evictor_unit_macros.svh =====
// Assertion macros for the evictor
`ifndef SIZE_BUDGET_LRU_EVICTOR_UNIT_MACROS_SVH
`define SIZE_BUDGET_LRU_EVICTOR_UNIT_MACROS_SVH
`ifndef SYNTHESIS
// check a property on every rising clock edge outside reset
`define SBL_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("sbl check failed");
// check that a condition never holds
`define SBL_NEVER(label, clk, rst_n, cond) \
  `SBL_ASSERT(label, clk, rst_n, !(cond))
`else
`define SBL_ASSERT(label, clk, rst_n, prop)
`define SBL_NEVER(label, clk, rst_n, cond)
`endif
`endif

// ===== hw/rtl/sbl_pkg.sv =====
`timescale 1ns / 1ps
package sbl_pkg;
  localparam int ENTRIES_PER_CLASS_DEF = 16;
  localparam logic [31:0] BUDGET0_RESET = 32'd268435456;
  localparam logic [31:0] BUDGET1_RESET = 32'd536870912;

  localparam logic [1:0] OP_TOUCH  = 2'd0;
  localparam logic [1:0] OP_REMOVE = 2'd1;
  localparam logic [1:0] OP_TIDY   = 2'd2;
  localparam logic [1:0] OP_SETBLK = 2'd3;

  localparam logic [1:0] KIND_DONE  = 2'd0;
  localparam logic [1:0] KIND_EVICT = 2'd1;
  localparam logic [1:0] KIND_WARN  = 2'd2;
  localparam logic [1:0] KIND_FULL  = 2'd3;

  localparam logic CFG_BUDGET0 = 1'b0;

  typedef struct packed {
    logic [1:0]  operation;
    logic        entry_class;
    logic [31:0] entry_id;
    logic [31:0] entry_size;
    logic        blocked_flag;
  } in_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] result_id;
    logic        result_class;
    logic [39:0] used_total;
    logic        last;
  } out_t;

  typedef struct packed {
    logic [31:0] id;
    logic [31:0] size;
    logic        blk;
  } entry_t;
endpackage

// ===== hw/rtl/size_budget_lru_evictor_unit.sv =====
`timescale 1ns / 1ps
// Channel | Ports                             | Direction
// input   | in_valid, in_stall, in_data       | item in, stall out
// result  | out_valid, out_stall, out_data    | item out, stall in
// config  | cfg_valid, cfg_ready, cfg_index,  | write in, ready always high
//         | cfg_data                          |
// One item at a time; touch searches the list, shifts entries towards the tail and
// writes the touched entry at the head; remove searches and closes the gap; set
// blocked searches and rewrites the flag. Tidy walks each class from the tail and,
// per eviction, moves the later entries up to close the gap.
// Reset (rst_n low, synchronous) empties both lists and restores the budgets.
// A stalled result holds the sequencer in its emit step until taken.
`include "size_budget_lru_evictor_unit_macros.svh"
module size_budget_lru_evictor_unit
  import sbl_pkg::*;
#(
  parameter int ENTRIES_PER_CLASS = ENTRIES_PER_CLASS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  in_t         in_data,
  output logic        out_valid,
  input  logic        out_stall,
  output out_t        out_data,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [31:0] cfg_data
);
  localparam int IW = $clog2(ENTRIES_PER_CLASS);
  localparam int CW = $clog2(ENTRIES_PER_CLASS + 1);
  localparam int AW = IW + 1;
  localparam logic [CW-1:0] FULL_CNT = CW'(ENTRIES_PER_CLASS);

  // one-hot sequencer
  typedef enum logic [14:0] {
    S_IDLE  = 15'h0001,
    S_SRD   = 15'h0002,  // issue search read
    S_SCMP  = 15'h0004,  // compare read id
    S_SUR   = 15'h0008,  // shift towards tail: read
    S_SUW   = 15'h0010,  // shift towards tail: write
    S_FRONT = 15'h0020,  // write touched entry at head
    S_SDR   = 15'h0040,  // close gap: read
    S_SDW   = 15'h0080,  // close gap: write
    S_TWALK = 15'h0100,  // tidy: step towards head
    S_TCHK  = 15'h0200,  // tidy: examine entry
    S_TEND  = 15'h0400,  // tidy: warning check
    S_TNEXT = 15'h0800,  // tidy: next class or finish
    S_EMIT  = 15'h1000   // load result register
  } state_t;

  state_t state_r, state_nxt, ret_r, ret_nxt;

  logic [1:0]  op_r, op_nxt;
  logic        cls_r, cls_nxt;
  logic [31:0] id_r, id_nxt;
  logic [31:0] size_r, size_nxt;
  logic        flag_r, flag_nxt;
  logic [CW-1:0] idx_r, idx_nxt, jdx_r, jdx_nxt;
  logic [CW-1:0] cnt_r [2];
  logic [CW-1:0] cnt_nxt [2];
  logic [39:0] bytes_r [2];
  logic [39:0] bytes_nxt [2];
  logic        warned_r [2];
  logic        warned_nxt [2];
  logic [31:0] budget_r [2];
  entry_t      tent_r, tent_nxt;
  logic [1:0]  ek_r, ek_nxt;
  logic [31:0] eid_r, eid_nxt;
  logic        ecls_r, ecls_nxt;
  logic        elast_r, elast_nxt;
  logic        out_valid_r;
  out_t        out_r;

  // entry store: both classes, class selects the upper address bit
  entry_t      mem [2**AW];
  entry_t      rd_q;
  logic          rd_en, we;
  logic [AW-1:0] rd_addr, wr_addr;
  entry_t        wr_data;

  always_ff @(posedge clk) begin
    if (rd_en) rd_q <= mem[rd_addr];
    if (we) mem[wr_addr] <= wr_data;
  end

  logic over;
  assign over = bytes_r[cls_r] > {8'd0, budget_r[cls_r]};

  assign in_stall  = (state_r != S_IDLE);
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  always_comb begin
    state_nxt = state_r;
    ret_nxt   = ret_r;
    op_nxt    = op_r;
    cls_nxt   = cls_r;
    id_nxt    = id_r;
    size_nxt  = size_r;
    flag_nxt  = flag_r;
    idx_nxt   = idx_r;
    jdx_nxt   = jdx_r;
    cnt_nxt   = cnt_r;
    bytes_nxt = bytes_r;
    warned_nxt = warned_r;
    tent_nxt  = tent_r;
    ek_nxt    = ek_r;
    eid_nxt   = eid_r;
    ecls_nxt  = ecls_r;
    elast_nxt = elast_r;
    rd_en     = 1'b0;
    rd_addr   = '0;
    we        = 1'b0;
    wr_addr   = '0;
    wr_data   = rd_q;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          op_nxt   = in_data.operation;
          cls_nxt  = (in_data.operation == OP_TIDY) ? 1'b0 : in_data.entry_class;
          id_nxt   = in_data.entry_id;
          size_nxt = in_data.entry_size;
          flag_nxt = in_data.blocked_flag;
          idx_nxt  = '0;
          jdx_nxt  = cnt_r[0];
          state_nxt = (in_data.operation == OP_TIDY) ? S_TWALK : S_SRD;
        end
      end
      S_SRD: begin
        if (idx_r == cnt_r[cls_r]) begin
          // id not in the list
          ek_nxt = KIND_DONE; eid_nxt = '0; ecls_nxt = cls_r; elast_nxt = 1'b1;
          ret_nxt = S_IDLE;
          state_nxt = S_EMIT;
          if (op_r == OP_TOUCH) begin
            if (cnt_r[cls_r] == FULL_CNT) begin
              ek_nxt = KIND_FULL;
            end else begin
              tent_nxt = '{id: id_r, size: 32'd0, blk: 1'b0};
              cnt_nxt[cls_r] = cnt_r[cls_r] + CW'(1);
              state_nxt = S_SUR;
            end
          end
        end else begin
          rd_en = 1'b1;
          rd_addr = {cls_r, idx_r[IW-1:0]};
          state_nxt = S_SCMP;
        end
      end
      S_SCMP: begin
        if (rd_q.id == id_r) begin
          ek_nxt = KIND_DONE; eid_nxt = '0; ecls_nxt = cls_r; elast_nxt = 1'b1;
          ret_nxt = S_IDLE;
          case (op_r)
            OP_TOUCH: begin
              tent_nxt = rd_q;
              state_nxt = S_SUR;
            end
            OP_REMOVE: begin
              bytes_nxt[cls_r] = bytes_r[cls_r] - {8'd0, rd_q.size};
              state_nxt = S_SDR;
            end
            default: begin
              we = 1'b1;
              wr_addr = {cls_r, idx_r[IW-1:0]};
              wr_data = '{id: rd_q.id, size: rd_q.size, blk: flag_r};
              state_nxt = S_EMIT;
            end
          endcase
        end else begin
          idx_nxt = idx_r + CW'(1);
          state_nxt = S_SRD;
        end
      end
      S_SUR: begin
        if (idx_r == '0) begin
          state_nxt = S_FRONT;
        end else begin
          rd_en = 1'b1;
          rd_addr = {cls_r, IW'(idx_r - CW'(1))};
          state_nxt = S_SUW;
        end
      end
      S_SUW: begin
        we = 1'b1;
        wr_addr = {cls_r, idx_r[IW-1:0]};
        idx_nxt = idx_r - CW'(1);
        state_nxt = S_SUR;
      end
      S_FRONT: begin
        we = 1'b1;
        wr_addr = {cls_r, IW'(0)};
        wr_data = '{id: tent_r.id, size: size_r, blk: tent_r.blk};
        bytes_nxt[cls_r] = bytes_r[cls_r] - {8'd0, tent_r.size} + {8'd0, size_r};
        state_nxt = S_EMIT;
      end
      S_SDR: begin
        if ((idx_r + CW'(1)) >= cnt_r[cls_r]) begin
          cnt_nxt[cls_r] = cnt_r[cls_r] - CW'(1);
          state_nxt = S_EMIT;
        end else begin
          rd_en = 1'b1;
          rd_addr = {cls_r, IW'(idx_r + CW'(1))};
          state_nxt = S_SDW;
        end
      end
      S_SDW: begin
        we = 1'b1;
        wr_addr = {cls_r, idx_r[IW-1:0]};
        idx_nxt = idx_r + CW'(1);
        state_nxt = S_SDR;
      end
      S_TWALK: begin
        if (jdx_r == '0 || !over) begin
          state_nxt = S_TEND;
        end else begin
          jdx_nxt = jdx_r - CW'(1);
          rd_en = 1'b1;
          rd_addr = {cls_r, IW'(jdx_r - CW'(1))};
          state_nxt = S_TCHK;
        end
      end
      S_TCHK: begin
        if (!rd_q.blk) begin
          bytes_nxt[cls_r] = bytes_r[cls_r] - {8'd0, rd_q.size};
          ek_nxt = KIND_EVICT; eid_nxt = rd_q.id; ecls_nxt = cls_r; elast_nxt = 1'b0;
          ret_nxt = S_TWALK;
          idx_nxt = jdx_r;
          state_nxt = S_SDR;
        end else begin
          state_nxt = S_TWALK;
        end
      end
      S_TEND: begin
        state_nxt = S_TNEXT;
        if (over) begin
          if (!warned_r[cls_r]) begin
            warned_nxt[cls_r] = 1'b1;
            ek_nxt = KIND_WARN; eid_nxt = '0; ecls_nxt = cls_r; elast_nxt = 1'b0;
            ret_nxt = S_TNEXT;
            state_nxt = S_EMIT;
          end
        end else begin
          warned_nxt[cls_r] = 1'b0;
        end
      end
      S_TNEXT: begin
        if (!cls_r) begin
          cls_nxt = 1'b1;
          jdx_nxt = cnt_r[1];
          state_nxt = S_TWALK;
        end else begin
          ek_nxt = KIND_DONE; eid_nxt = '0; ecls_nxt = 1'b1; elast_nxt = 1'b1;
          ret_nxt = S_IDLE;
          state_nxt = S_EMIT;
        end
      end
      S_EMIT: begin
        if (!out_valid_r || !out_stall) state_nxt = ret_r;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      ret_r       <= S_IDLE;
      cnt_r       <= '{default: '0};
      bytes_r     <= '{default: '0};
      warned_r    <= '{default: 1'b0};
      budget_r[0] <= BUDGET0_RESET;
      budget_r[1] <= BUDGET1_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      ret_r    <= ret_nxt;
      cnt_r    <= cnt_nxt;
      bytes_r  <= bytes_nxt;
      warned_r <= warned_nxt;
      if (cfg_valid) begin
        if (cfg_index == CFG_BUDGET0) budget_r[0] <= cfg_data;
        else budget_r[1] <= cfg_data;
      end
      // load on emit, drop once taken
      if (state_r == S_EMIT && (!out_valid_r || !out_stall)) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    op_r    <= op_nxt;
    cls_r   <= cls_nxt;
    id_r    <= id_nxt;
    size_r  <= size_nxt;
    flag_r  <= flag_nxt;
    idx_r   <= idx_nxt;
    jdx_r   <= jdx_nxt;
    tent_r  <= tent_nxt;
    ek_r    <= ek_nxt;
    eid_r   <= eid_nxt;
    ecls_r  <= ecls_nxt;
    elast_r <= elast_nxt;
    if (state_r == S_EMIT && (!out_valid_r || !out_stall)) begin
      out_r <= '{kind: ek_r, result_id: eid_r, result_class: ecls_r,
                 used_total: bytes_r[ecls_r], last: elast_r};
    end
  end

  `SBL_NEVER(a_cnt_bound, clk, rst_n, cnt_r[0] > FULL_CNT || cnt_r[1] > FULL_CNT)
  `SBL_ASSERT(a_busy_after_accept, clk, rst_n, (in_valid && !in_stall) |=> state_r != S_IDLE)
  `SBL_NEVER(a_write_state, clk, rst_n, we && state_r != S_SUW && state_r != S_SDW && state_r != S_FRONT && state_r != S_SCMP)
endmodule

// ===== sim/size_budget_lru_evictor_unit_tb.sv =====
`timescale 1ns / 1ps
module size_budget_lru_evictor_unit_tb;
  import sbl_pkg::*;

  localparam int  SLOTS       = 16;
  localparam logic CFG_BUDGET1 = 1'b1;
  localparam int  CYCLE_LIMIT = 1000000;
  // results are drained by then; pad a little before a budget write
  localparam int  SETTLE      = 200;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  in_t         in_data;
  logic        out_valid;
  logic        out_stall;
  out_t        out_data;
  logic        cfg_valid;
  logic        cfg_ready;
  logic        cfg_index;
  logic [31:0] cfg_data;

  size_budget_lru_evictor_unit dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    clk = 1'b1; #5;
    clk = 1'b0; #5;
  end

  // Shadow copy of the evictor: per-class recency lists, totals and budgets
  logic [31:0] shadow_ids   [2][SLOTS];
  logic [31:0] shadow_sizes [2][SLOTS];
  logic        shadow_blk   [2][SLOTS];
  int          shadow_count [2];
  logic [39:0] shadow_used  [2];
  logic        shadow_warned[2];
  logic [31:0] shadow_budget[2];

  out_t expected_results[$];
  int   mismatches;
  int   cycles;
  int   burst_left;

  function automatic int find_slot(int c, logic [31:0] id);
    for (int i = 0; i < shadow_count[c]; i++)
      if (shadow_ids[c][i] == id) return i;
    return -1;
  endfunction

  function automatic void drop_slot(int c, int j);
    for (int k = j; k + 1 < shadow_count[c]; k++) begin
      shadow_ids[c][k]   = shadow_ids[c][k+1];
      shadow_sizes[c][k] = shadow_sizes[c][k+1];
      shadow_blk[c][k]   = shadow_blk[c][k+1];
    end
    shadow_count[c]--;
  endfunction

  function automatic void push_result(logic [1:0] kind, logic [31:0] id, int c);
    out_t r;
    r.kind = kind;
    r.result_id = id;
    r.result_class = c[0];
    r.used_total = shadow_used[c];
    r.last = 1'b0;
    expected_results.push_back(r);
  endfunction

  // Advance the shadow state by one item and queue the results it causes
  function automatic void predict_evictor(in_t it);
    int          c;
    int          pos;
    int          j;
    logic [31:0] tid;
    logic [31:0] tsz;
    logic        tbl;
    out_t        tail;
    c = it.entry_class;
    case (it.operation)
      OP_TOUCH: begin
        pos = find_slot(c, it.entry_id);
        if (pos < 0 && shadow_count[c] >= SLOTS) begin
          push_result(KIND_FULL, 32'd0, c);
        end else begin
          if (pos < 0) begin
            pos = shadow_count[c];
            shadow_ids[c][pos]   = it.entry_id;
            shadow_sizes[c][pos] = 32'd0;
            shadow_blk[c][pos]   = 1'b0;
            shadow_count[c]++;
          end
          tid = shadow_ids[c][pos];
          tsz = shadow_sizes[c][pos];
          tbl = shadow_blk[c][pos];
          for (int k = pos; k > 0; k--) begin
            shadow_ids[c][k]   = shadow_ids[c][k-1];
            shadow_sizes[c][k] = shadow_sizes[c][k-1];
            shadow_blk[c][k]   = shadow_blk[c][k-1];
          end
          shadow_ids[c][0]   = tid;
          shadow_sizes[c][0] = it.entry_size;
          shadow_blk[c][0]   = tbl;
          shadow_used[c] = shadow_used[c] - {8'd0, tsz} + {8'd0, it.entry_size};
          push_result(KIND_DONE, 32'd0, c);
        end
      end
      OP_REMOVE: begin
        pos = find_slot(c, it.entry_id);
        if (pos >= 0) begin
          shadow_used[c] = shadow_used[c] - {8'd0, shadow_sizes[c][pos]};
          drop_slot(c, pos);
        end
        push_result(KIND_DONE, 32'd0, c);
      end
      OP_SETBLK: begin
        pos = find_slot(c, it.entry_id);
        if (pos >= 0) shadow_blk[c][pos] = it.blocked_flag;
        push_result(KIND_DONE, 32'd0, c);
      end
      default: begin
        for (int cl = 0; cl < 2; cl++) begin
          j = shadow_count[cl];
          while (j > 0) begin
            j--;
            if (shadow_used[cl] <= {8'd0, shadow_budget[cl]}) break;
            if (!shadow_blk[cl][j]) begin
              tid = shadow_ids[cl][j];
              shadow_used[cl] = shadow_used[cl] - {8'd0, shadow_sizes[cl][j]};
              drop_slot(cl, j);
              push_result(KIND_EVICT, tid, cl);
            end
          end
          if (shadow_used[cl] > {8'd0, shadow_budget[cl]}) begin
            if (!shadow_warned[cl]) begin
              shadow_warned[cl] = 1'b1;
              push_result(KIND_WARN, 32'd0, cl);
            end
          end else begin
            shadow_warned[cl] = 1'b0;
          end
        end
        push_result(KIND_DONE, 32'd0, 1);
      end
    endcase
    tail = expected_results.pop_back();
    tail.last = 1'b1;
    expected_results.push_back(tail);
  endfunction

  // Send one item; bursts of random length with random gaps between them
  task automatic send_item(logic [1:0] op, logic c, logic [31:0] id, logic [31:0] size,
                           logic flag);
    in_t it;
    int  gap;
    it.operation = op;
    it.entry_class = c;
    it.entry_id = id;
    it.entry_size = size;
    it.blocked_flag = flag;
    in_valid <= 1'b1;
    in_data  <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_evictor(it);
    if (burst_left > 0) burst_left--;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  // Drop valid and wait for every outstanding result, then let the block settle
  task automatic drain_block();
    if (in_valid) in_valid <= 1'b0;
    @(posedge clk);
    while (expected_results.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_budget(logic idx, logic [31:0] value);
    drain_block();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    shadow_budget[idx] = value;
  endtask

  // Extremes of every field, unknown ids and a first tidy at the reset budgets
  task automatic test_basic_ops();
    send_item(OP_TOUCH, 1'b0, 32'd0, 32'd0, 1'b0);
    send_item(OP_TOUCH, 1'b0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
    send_item(OP_SETBLK, 1'b0, 32'hFFFF_FFFF, 32'd0, 1'b1);
    send_item(OP_REMOVE, 1'b1, 32'd5, 32'd0, 1'b0);
    send_item(OP_SETBLK, 1'b1, 32'd7, 32'd0, 1'b1);
    send_item(OP_TIDY, 1'b0, 32'd0, 32'd0, 1'b0);
    send_item(OP_REMOVE, 1'b0, 32'hFFFF_FFFF, 32'd0, 1'b0);
  endtask

  // Fill class 1, then touch a stranger (table full) and a member (hit)
  task automatic test_table_full();
    for (int i = 0; i < SLOTS; i++)
      send_item(OP_TOUCH, 1'b1, 32'd100 + i, 32'd1000, 1'b0);
    send_item(OP_TOUCH, 1'b1, 32'd200, 32'd5, 1'b0);
    send_item(OP_TOUCH, 1'b1, 32'd105, 32'd7, 1'b0);
  endtask

  // Zero and full-scale budgets; the warning fires once per over-budget episode
  task automatic test_budget_extremes();
    write_budget(CFG_BUDGET0, 32'd0);
    write_budget(CFG_BUDGET1, 32'hFFFF_FFFF);
    send_item(OP_TOUCH, 1'b0, 32'd1, 32'd1, 1'b0);
    send_item(OP_SETBLK, 1'b0, 32'd1, 32'd0, 1'b1);
    send_item(OP_TIDY, 1'b1, 32'd0, 32'd0, 1'b0);
    send_item(OP_TIDY, 1'b0, 32'd0, 32'd0, 1'b0);
    send_item(OP_SETBLK, 1'b0, 32'd1, 32'd0, 1'b0);
    send_item(OP_TIDY, 1'b0, 32'd0, 32'd0, 1'b0);
  endtask

  // Mostly small id pools and sizes so lists fill and tidies evict
  task automatic test_random();
    int          pick;
    logic [1:0]  op;
    logic [31:0] id;
    logic [31:0] size;
    for (int phase = 0; phase < 4; phase++) begin
      write_budget(CFG_BUDGET0, (phase == 3) ? 32'hFFFF_FFFF : $urandom_range(0, 9000));
      write_budget(CFG_BUDGET1, (phase == 2) ? 32'd0 : $urandom_range(0, 9000));
      for (int n = 0; n < 62; n++) begin
        pick = $urandom_range(0, 99);
        op = (pick < 50) ? OP_TOUCH : (pick < 65) ? OP_REMOVE :
             (pick < 80) ? OP_SETBLK : OP_TIDY;
        id   = ($urandom_range(0, 9) == 0) ? $urandom() : $urandom_range(0, 22);
        size = ($urandom_range(0, 19) == 0) ? $urandom() : $urandom_range(0, 1500);
        send_item(op, $urandom_range(0, 1), id, size, $urandom_range(0, 1));
      end
    end
  endtask

  // Receiver stall pattern: free-flowing stretches, light and heavy stalling
  int stall_mode;
  int stall_left;
  always @(posedge clk) begin
    if (stall_left == 0) begin
      stall_mode = $urandom_range(0, 2);
      stall_left = $urandom_range(5, 40);
    end
    stall_left--;
    case (stall_mode)
      0: out_stall <= 1'b0;
      1: out_stall <= ($urandom_range(0, 3) == 0);
      default: out_stall <= ($urandom_range(0, 1) == 0);
    endcase
  end

  // Compare each accepted result against the oldest expectation
  always @(posedge clk) begin
    out_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result: got %p", out_data);
      end else begin
        want = expected_results.pop_front();
        if (out_data.kind !== want.kind || out_data.result_id !== want.result_id ||
            out_data.result_class !== want.result_class ||
            out_data.used_total !== want.used_total || out_data.last !== want.last) begin
          mismatches++;
          if (mismatches <= 10) $display("result mismatch: expected %p got %p", want, out_data);
        end
      end
    end
  end

  // Hold a hard ceiling on run length
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin
    mismatches = 0;
    cycles = 0;
    burst_left = 0;
    stall_left = 0;
    rst_n     <= 1'b0;
    in_valid  <= 1'b0;
    in_data   <= '0;
    out_stall <= 1'b0;
    cfg_valid <= 1'b0;
    cfg_index <= 1'b0;
    cfg_data  <= '0;
    for (int c = 0; c < 2; c++) begin
      shadow_count[c] = 0;
      shadow_used[c] = '0;
      shadow_warned[c] = 1'b0;
      for (int i = 0; i < SLOTS; i++) shadow_blk[c][i] = 1'b0;
    end
    shadow_budget[0] = BUDGET0_RESET;
    shadow_budget[1] = BUDGET1_RESET;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_basic_ops();
    test_table_full();
    test_budget_extremes();
    test_random();

    drain_block();
    if (expected_results.size() != 0) mismatches++;
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end
endmodule

// ===== sim.f =====
+incdir+hw/rtl
hw/rtl/sbl_pkg.sv
hw/rtl/size_budget_lru_evictor_unit.sv
sim/size_budget_lru_evictor_unit_tb.sv
